FILE: design/wsla_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsla_pkg
// Shared types and constants of the weighted smooth-L1 loss accumulator.
// ----------------------------------------------------------------------------
package wsla_pkg;

	localparam int MAX_ITEMS_LOG2 = 24;

	localparam int WSUM_SH = MAX_ITEMS_LOG2 + 16;
	localparam logic [39:0] WSUM_MAX = (WSUM_SH >= 40) ? 40'hFF_FFFF_FFFF :
		40'((64'd1 << WSUM_SH) - 64'd1);

	localparam logic [47:0] LOSS_MAX    = 48'hFFFF_FFFF_FFFF;
	localparam logic [15:0] ONE_Q8_8    = 16'd256;
	localparam logic [23:0] HALF_Q16_16 = 24'h00_8000;

	// restoring divide of a Q24.24 sum shifted up by 8 bits
	localparam int DIV_STEPS = 56;
	localparam int CNT_W     = $clog2(DIV_STEPS);
	localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(DIV_STEPS - 1);

	localparam logic REG_SIZE_AVERAGE = 1'b0;
	localparam logic REG_USE_WEIGHTS  = 1'b1;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	// one classified element handed from front to back
	typedef struct packed {
		logic [39:0] prod;
		logic [15:0] weight;
		logic        last;
	} entry_t;

	typedef enum logic {
		BK_ACC,
		BK_DIV
	} back_state_t;

endpackage

FILE: design/weighted_smooth_l1_loss_accumulator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// weighted_smooth_l1_loss_accumulator
// Streams prediction/target/weight elements and reports the Huber loss sum, or its average over the weight total.
// ----------------------------------------------------------------------------
// Usage:
// s_* carries one element per request: prediction, target and weight in
// s_tdata, s_tlast on the final element of a tensor. m_* returns one result
// per tensor: loss and weight total in m_tdata, saturation flag in m_tuser.
// Elements that are not last are taken one per cycle while the queue has room;
// the front pipeline is three stages deep and feeds a four-entry queue that
// the accumulator drains at one element per cycle except while it divides.
// A last element raises m_tvalid once it has passed the front stages and the
// queue and, when averaging divides by a nonzero weight total, only after a
// restoring divider that retires one quotient bit per cycle; elements queue up behind it.
// A stalled m_tready holds the result; the next tensor keeps accumulating
// and only its own last element waits for the result register.
// cfg_we writes size_average (index 0) or use_weights (index 1).
// Reset clears the accumulators, the queue and the output valid; size_average
// resets to 1 and use_weights to 0.
// ----------------------------------------------------------------------------
module weighted_smooth_l1_loss_accumulator
	import wsla_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic        cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // prediction[15:0], target_value[31:16], elem_weight[47:32]
	input  logic        s_tlast,   // last_elem
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [87:0] m_tdata,   // loss[47:0], weight_total[87:48]
	output logic        m_tuser    // saturated
);

	logic   size_average_q;
	logic   use_weights_q;
	logic   push, queue_ready, pop, head_valid;
	entry_t push_entry, head;
	logic [47:0] loss;
	logic [39:0] weight_total;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_average_q <= 1'b1;
			use_weights_q  <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SIZE_AVERAGE: size_average_q <= cfg_data;
				REG_USE_WEIGHTS:  use_weights_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	wsla_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.use_weights (use_weights_q),
		.in_valid    (s_tvalid),
		.in_ready    (s_tready),
		.prediction  (s_tdata[15:0]),
		.target_value(s_tdata[31:16]),
		.elem_weight (s_tdata[47:32]),
		.last_elem   (s_tlast),
		.push        (push),
		.push_entry  (push_entry),
		.queue_ready (queue_ready)
	);

	wsla_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_entry(push_entry),
		.not_full  (queue_ready),
		.pop       (pop),
		.not_empty (head_valid),
		.head      (head)
	);

	wsla_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.size_average(size_average_q),
		.head_valid  (head_valid),
		.head        (head),
		.pop         (pop),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.loss        (loss),
		.weight_total(weight_total),
		.saturated   (m_tuser)
	);

	assign m_tdata = {weight_total, loss};

endmodule

FILE: design/wsla_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsla_front
// Input stage: absolute difference, Huber term and weighted product.
// ----------------------------------------------------------------------------
module wsla_front
	import wsla_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        use_weights,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [15:0] prediction,
	input  logic [15:0] target_value,
	input  logic [15:0] elem_weight,
	input  logic        last_elem,
	output logic        push,
	output entry_t      push_entry,
	input  logic        queue_ready
);

	logic        v_s1, v_s2, v_s3;
	logic [15:0] z_s1;
	logic [15:0] w_s1, w_s2, w_s3;
	logic        last_s1, last_s2, last_s3;
	logic [23:0] term_s2;
	logic [39:0] prod_s3;

	logic        adv1, adv2, adv3;
	logic [16:0] diff;
	logic [16:0] abs_diff;
	logic [15:0] zz;
	logic [23:0] term;

	assign adv3     = !v_s3 || queue_ready;
	assign adv2     = !v_s2 || adv3;
	assign adv1     = !v_s1 || adv2;
	assign in_ready = adv1;

	assign diff     = {prediction[15], prediction} - {target_value[15], target_value};
	assign abs_diff = diff[16] ? (~diff + 17'd1) : diff;

	// z below 1.0 squares only its fraction byte
	assign zz   = z_s1[7:0] * z_s1[7:0];
	assign term = (z_s1 < ONE_Q8_8) ? {9'd0, zz[15:1]} : ({z_s1, 8'd0} - HALF_Q16_16);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (adv1) v_s1 <= in_valid;
			if (adv2) v_s2 <= v_s1;
			if (adv3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			z_s1    <= abs_diff[15:0];
			w_s1    <= use_weights ? elem_weight : ONE_Q8_8;
			last_s1 <= last_elem;
		end
		if (adv2) begin
			term_s2 <= term;
			w_s2    <= w_s1;
			last_s2 <= last_s1;
		end
		if (adv3) begin
			prod_s3 <= term_s2 * w_s2;
			w_s3    <= w_s2;
			last_s3 <= last_s2;
		end
	end

	assign push              = v_s3 && queue_ready;
	assign push_entry.prod   = prod_s3;
	assign push_entry.weight = w_s3;
	assign push_entry.last   = last_s3;

endmodule

FILE: design/wsla_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsla_queue
// Short first-in first-out queue between the front and back parts.
// ----------------------------------------------------------------------------
module wsla_queue
	import wsla_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  entry_t push_entry,
	output logic   not_full,
	input  logic   pop,
	output logic   not_empty,
	output entry_t head
);

	entry_t              slots_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wr_q, rd_q;
	logic [QPTR_W:0]     count_q;

	assign not_full  = count_q != (QPTR_W+1)'(QUEUE_DEPTH);
	assign not_empty = count_q != '0;
	assign head      = slots_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop)  rd_q <= rd_q + 1'b1;
			if (push && !pop)      count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) slots_q[wr_q] <= push_entry;
	end

endmodule

FILE: design/wsla_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsla_back
// Saturating accumulators, final averaging divide and result register.
// ----------------------------------------------------------------------------
module wsla_back
	import wsla_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        size_average,
	input  logic        head_valid,
	input  entry_t      head,
	output logic        pop,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [47:0] loss,
	output logic [39:0] weight_total,
	output logic        saturated
);

	back_state_t state_q, state_d;

	logic [47:0] lsum_q;
	logic [39:0] wsum_q;
	logic        ovf_q;

	logic [55:0]      dq_q;
	logic [39:0]      div_d_q;
	logic [39:0]      rem_q;
	logic [CNT_W-1:0] cnt_q;
	logic [39:0]      res_w_q;
	logic             res_sat_q;

	logic        out_v_q;
	logic [47:0] out_loss_q;
	logic [39:0] out_w_q;
	logic        out_sat_q;

	logic [48:0] lsum_add;
	logic [40:0] wsum_add;
	logic        lovf, wovf;
	logic [47:0] lsum_new;
	logic [39:0] wsum_new;
	logic        sat_new;
	logic        start_div;
	logic [40:0] rem_sh;
	logic        ge;
	logic [40:0] rem_next;
	logic [55:0] quo_next;
	logic        div_done;

	assign lsum_add = {1'b0, lsum_q} + {9'd0, head.prod};
	assign lovf     = lsum_add[48];
	assign lsum_new = lovf ? LOSS_MAX : lsum_add[47:0];
	assign wsum_add = {1'b0, wsum_q} + {25'd0, head.weight};
	assign wovf     = wsum_add > {1'b0, WSUM_MAX};
	assign wsum_new = wovf ? WSUM_MAX : wsum_add[39:0];
	assign sat_new  = ovf_q || lovf || wovf;

	assign rem_sh   = {rem_q, dq_q[55]};
	assign ge       = rem_sh >= {1'b0, div_d_q};
	assign rem_next = ge ? (rem_sh - {1'b0, div_d_q}) : rem_sh;
	assign quo_next = {dq_q[54:0], ge};

	// a last element waits until the result register is free
	always_comb begin
		pop       = 1'b0;
		start_div = 1'b0;
		div_done  = 1'b0;
		unique case (state_q)
			BK_ACC: begin
				pop       = head_valid && (!head.last || !out_v_q);
				start_div = pop && head.last && size_average && (wsum_new != '0);
			end
			BK_DIV: begin
				div_done = cnt_q == DIV_LAST;
			end
			default: ;
		endcase
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_ACC:  if (start_div) state_d = BK_DIV;
			BK_DIV:  if (div_done)  state_d = BK_ACC;
			default: state_d = BK_ACC;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_ACC;
			lsum_q  <= '0;
			wsum_q  <= '0;
			ovf_q   <= 1'b0;
			out_v_q <= 1'b0;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (out_v_q && out_ready) out_v_q <= 1'b0;
			if (pop) begin
				if (head.last) begin
					lsum_q <= '0;
					wsum_q <= '0;
					ovf_q  <= 1'b0;
					if (!start_div) out_v_q <= 1'b1;
				end else begin
					lsum_q <= lsum_new;
					wsum_q <= wsum_new;
					ovf_q  <= sat_new;
				end
			end
			if (start_div) cnt_q <= '0;
			else if (state_q == BK_DIV) cnt_q <= cnt_q + 1'b1;
			if (div_done) out_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start_div) begin
			dq_q      <= {lsum_new, 8'd0};
			div_d_q   <= wsum_new;
			rem_q     <= '0;
			res_w_q   <= wsum_new;
			res_sat_q <= sat_new;
		end else if (state_q == BK_DIV) begin
			dq_q  <= quo_next;
			rem_q <= rem_next[39:0];
		end
		if (pop && head.last && !start_div) begin
			out_loss_q <= lsum_new;
			out_w_q    <= wsum_new;
			out_sat_q  <= sat_new;
		end else if (div_done) begin
			// quotient beyond 48 bits clamps
			out_loss_q <= (quo_next[55:48] != '0) ? LOSS_MAX : quo_next[47:0];
			out_w_q    <= res_w_q;
			out_sat_q  <= res_sat_q || (quo_next[55:48] != '0);
		end
	end

	assign out_valid    = out_v_q;
	assign loss         = out_loss_q;
	assign weight_total = out_w_q;
	assign saturated    = out_sat_q;

endmodule
